FILE: rtl/scph_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the segment versus convex polygon hit block.
package scph_pkg;

	localparam int COORD_BITS       = 16;
	localparam int IDX_BITS         = 4;
	localparam int CFG_BITS         = 5;
	localparam int MAX_VERTICES_DEF = 16;
	localparam int unsigned MIN_POLY_VERTICES = 3;

	// operand, product and determinant widths of the cross-product unit
	localparam int OPW   = COORD_BITS + 2;
	localparam int PRODW = 2 * OPW;
	localparam int CRW   = PRODW + 1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                         op;
		logic [IDX_BITS-1:0]          vertex_index;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
		logic signed [COORD_BITS-1:0] dir_x;
		logic signed [COORD_BITS-1:0] dir_y;
	} req_t;

	typedef struct packed {
		logic hit;
		logic endpoint_inside;
	} rsp_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} vtx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD0,
		ST_LOAD1,
		ST_EDGE,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// determinant kinds issued per edge, in issue order
	typedef enum logic [2:0] {
		XOP_IN_O,
		XOP_IN_E,
		XOP_DEN,
		XOP_N1,
		XOP_N2
	} xop_t;

endpackage

FILE: rtl/segment_convex_polygon_hit.sv
`timescale 1ns / 1ps
// Segment versus convex polygon hit test: top level with vertex memory and cross-product unit.
//
// Vertex write items (op 0) store one vertex in the vertex memory and return a result with both
// flags low. A query item (op 1) walks the polygon edges in table order through a single
// cross-product unit (two multipliers, one 2x2 determinant per cycle, three pipeline stages)
// that computes five determinants per edge: the side tests of origin and endpoint and the
// denominator and both numerators of the crossing test. A query walks vertex_count edges,
// clamped to MAX_VERTICES. The vertex memory has one port with a registered read, each used
// vertex read once per query. One item is in work at a time; a finished result waits in the
// output register while the next item is taken. vertex_count comes on the cfg channel, which
// is always ready; the user must write it only while the block is idle, which goes unchecked.
module segment_convex_polygon_hit #(
	parameter int MAX_VERTICES = scph_pkg::MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  scph_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output scph_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [scph_pkg::CFG_BITS-1:0] cfg_data
);

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int CB    = scph_pkg::COORD_BITS;
	localparam int OPW   = scph_pkg::OPW;
	localparam int PRODW = scph_pkg::PRODW;
	localparam int CRW   = scph_pkg::CRW;
	localparam int IB    = scph_pkg::IDX_BITS;
	localparam int FB    = scph_pkg::CFG_BITS;
	localparam int LW    = ((CW > FB) ? ((CW > IB) ? CW : IB) : ((FB > IB) ? FB : IB)) + 1;

	function automatic logic signed [OPW-1:0] sx(input logic signed [CB-1:0] v);
		sx = {{(OPW-CB){v[CB-1]}}, v};
	endfunction

	// num/den within [0,1], with den's sign giving the direction of the range
	function automatic logic in_unit(input logic signed [CRW-1:0] num,
	                                 input logic signed [CRW-1:0] den);
		logic pos;
		pos = !den[CRW-1] && (den != '0);
		if (pos) begin
			in_unit = !num[CRW-1] && (num <= den);
		end else begin
			in_unit = (num[CRW-1] || (num == '0)) && (num >= den);
		end
	endfunction

	scph_pkg::state_t state_q, state_d;
	scph_pkg::xop_t   step_q;
	logic [CW-1:0]    edge_q;
	logic [CW-1:0]    n_q;
	logic             qry_q;
	logic [FB-1:0]    vcount_q;

	logic signed [OPW-1:0] px_q, py_q, ex_q, ey_q, dx_q, dy_q;
	scph_pkg::vtx_t        v0_q, vi_q, vj_q, rd_q;
	scph_pkg::vtx_t        mem [MAX_VERTICES];

	logic signed [OPW-1:0]   ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [PRODW-1:0] p1_s2, p2_s2;
	logic signed [CRW-1:0]   cr_s3;
	logic signed [CRW-1:0]   den_q;
	scph_pkg::xop_t          tag_s1, tag_s2, tag_s3;
	logic                    v_s1, v_s2, v_s3;

	logic neg_o_q, neg_e_q, cross_q, den_nz_q, n1ok_q;
	logic rsp_valid_q;
	scph_pkg::rsp_t rsp_q;

	logic [LW-1:0] vcount_w, n_used_w, slot_w, next_w, n_w;
	logic [CW-1:0] n_used;
	logic          req_acc, rsp_free, last_edge, next_rd_ok, pipe_busy, slot_ok;
	logic          mem_we, mem_re, issue, rsp_load;
	logic [AW-1:0] rd_addr;
	logic signed [OPW-1:0] ax_d, ay_d, bx_d, by_d;
	logic signed [OPW-1:0] vix, viy, vjx, vjy, d2x, d2y, sxv, syv;
	logic          in_poly;

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign vcount_w = LW'(vcount_q);
	assign n_used_w = (vcount_w > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : vcount_w;
	assign n_used   = n_used_w[CW-1:0];
	assign slot_w   = LW'(req.vertex_index);
	assign slot_ok  = slot_w < LW'(MAX_VERTICES);
	assign n_w      = LW'(n_q);
	assign next_w   = LW'(edge_q) + LW'(2);

	assign req_acc    = req_valid && !req_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign last_edge  = edge_q == (n_q - CW'(1));
	assign next_rd_ok = next_w < n_w;
	assign pipe_busy  = v_s1 || v_s2 || v_s3;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scph_pkg::ST_IDLE: begin
				if (req_acc) begin
					if (req.op == scph_pkg::OP_QUERY && n_used != '0) begin
						state_d = scph_pkg::ST_LOAD0;
					end else begin
						state_d = scph_pkg::ST_FIN;
					end
				end
			end
			scph_pkg::ST_LOAD0: begin
				state_d = (n_q == CW'(1)) ? scph_pkg::ST_EDGE : scph_pkg::ST_LOAD1;
			end
			scph_pkg::ST_LOAD1: state_d = scph_pkg::ST_EDGE;
			scph_pkg::ST_EDGE: begin
				if (step_q == scph_pkg::XOP_N2 && last_edge) begin
					state_d = scph_pkg::ST_DRAIN;
				end
			end
			scph_pkg::ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = scph_pkg::ST_FIN;
				end
			end
			scph_pkg::ST_FIN: begin
				if (rsp_free) begin
					state_d = scph_pkg::ST_IDLE;
				end
			end
			default: state_d = scph_pkg::ST_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		rd_addr   = '0;
		issue     = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			scph_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				mem_we    = req_acc && req.op == scph_pkg::OP_WRITE && slot_ok;
				mem_re    = req_acc && req.op == scph_pkg::OP_QUERY && n_used != '0;
			end
			scph_pkg::ST_LOAD0: begin
				mem_re  = n_q != CW'(1);
				rd_addr = AW'(1);
			end
			scph_pkg::ST_LOAD1: ;
			scph_pkg::ST_EDGE: begin
				issue   = 1'b1;
				// fetch the vertex after next while this edge runs
				mem_re  = step_q == scph_pkg::XOP_IN_O && next_rd_ok;
				rd_addr = next_w[AW-1:0];
			end
			scph_pkg::ST_DRAIN: ;
			scph_pkg::ST_FIN: rsp_load = rsp_free;
			default: ;
		endcase
	end

	// vertex memory, one port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_w[AW-1:0]] <= '{x: req.coord_x, y: req.coord_y};
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	// operand selection
	always_comb begin
		vix = sx(vi_q.x);
		viy = sx(vi_q.y);
		vjx = sx(vj_q.x);
		vjy = sx(vj_q.y);
		d2x = vjx - vix;
		d2y = vjy - viy;
		sxv = px_q - vix;
		syv = py_q - viy;
		unique case (step_q)
			scph_pkg::XOP_IN_O: begin
				ax_d = vix - px_q;
				ay_d = viy - py_q;
				bx_d = vjx - px_q;
				by_d = vjy - py_q;
			end
			scph_pkg::XOP_IN_E: begin
				ax_d = vix - ex_q;
				ay_d = viy - ey_q;
				bx_d = vjx - ex_q;
				by_d = vjy - ey_q;
			end
			scph_pkg::XOP_DEN: begin
				ax_d = dx_q;
				ay_d = dy_q;
				bx_d = d2x;
				by_d = d2y;
			end
			scph_pkg::XOP_N1: begin
				ax_d = d2x;
				ay_d = d2y;
				bx_d = sxv;
				by_d = syv;
			end
			scph_pkg::XOP_N2: begin
				ax_d = dx_q;
				ay_d = dy_q;
				bx_d = sxv;
				by_d = syv;
			end
			default: begin
				ax_d = '0;
				ay_d = '0;
				bx_d = '0;
				by_d = '0;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			px_q <= sx(req.coord_x);
			py_q <= sx(req.coord_y);
			dx_q <= sx(req.dir_x);
			dy_q <= sx(req.dir_y);
			ex_q <= sx(req.coord_x) + sx(req.dir_x);
			ey_q <= sx(req.coord_y) + sx(req.dir_y);
		end
		if (state_q == scph_pkg::ST_LOAD0) begin
			v0_q <= rd_q;
			vi_q <= rd_q;
			if (n_q == CW'(1)) begin
				vj_q <= rd_q;
			end
		end else if (state_q == scph_pkg::ST_LOAD1) begin
			vj_q <= rd_q;
		end else if (issue && step_q == scph_pkg::XOP_N2 && !last_edge) begin
			vi_q <= vj_q;
			// closing edge wraps back to the first vertex
			vj_q <= ((edge_q + CW'(1)) == (n_q - CW'(1))) ? v0_q : rd_q;
		end
		ax_s1 <= ax_d;
		ay_s1 <= ay_d;
		bx_s1 <= bx_d;
		by_s1 <= by_d;
		p1_s2 <= PRODW'(ax_s1) * PRODW'(by_s1);
		p2_s2 <= PRODW'(bx_s1) * PRODW'(ay_s1);
		cr_s3 <= CRW'(p1_s2) - CRW'(p2_s2);
		if (v_s3 && tag_s3 == scph_pkg::XOP_DEN) begin
			den_q <= cr_s3;
		end
	end

	assign in_poly = qry_q && (n_w >= LW'(scph_pkg::MIN_POLY_VERTICES)) &&
	                 (!neg_o_q || !neg_e_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scph_pkg::ST_IDLE;
			step_q      <= scph_pkg::XOP_IN_O;
			edge_q      <= '0;
			n_q         <= '0;
			qry_q       <= 1'b0;
			vcount_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			tag_s1      <= scph_pkg::XOP_IN_O;
			tag_s2      <= scph_pkg::XOP_IN_O;
			tag_s3      <= scph_pkg::XOP_IN_O;
			neg_o_q     <= 1'b0;
			neg_e_q     <= 1'b0;
			cross_q     <= 1'b0;
			den_nz_q    <= 1'b0;
			n1ok_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			if (req_acc) begin
				n_q     <= n_used;
				qry_q   <= req.op == scph_pkg::OP_QUERY;
				edge_q  <= '0;
				step_q  <= scph_pkg::XOP_IN_O;
				neg_o_q <= 1'b0;
				neg_e_q <= 1'b0;
				cross_q <= 1'b0;
			end
			if (issue) begin
				unique case (step_q)
					scph_pkg::XOP_IN_O: step_q <= scph_pkg::XOP_IN_E;
					scph_pkg::XOP_IN_E: step_q <= scph_pkg::XOP_DEN;
					scph_pkg::XOP_DEN:  step_q <= scph_pkg::XOP_N1;
					scph_pkg::XOP_N1:   step_q <= scph_pkg::XOP_N2;
					scph_pkg::XOP_N2: begin
						step_q <= scph_pkg::XOP_IN_O;
						edge_q <= edge_q + CW'(1);
					end
					default: step_q <= scph_pkg::XOP_IN_O;
				endcase
			end
			v_s1   <= issue;
			tag_s1 <= step_q;
			v_s2   <= v_s1;
			tag_s2 <= tag_s1;
			v_s3   <= v_s2;
			tag_s3 <= tag_s2;
			if (v_s3) begin
				unique case (tag_s3)
					scph_pkg::XOP_IN_O: if (cr_s3[CRW-1]) neg_o_q <= 1'b1;
					scph_pkg::XOP_IN_E: if (cr_s3[CRW-1]) neg_e_q <= 1'b1;
					scph_pkg::XOP_DEN:  den_nz_q <= cr_s3 != '0;
					scph_pkg::XOP_N1:   n1ok_q <= in_unit(cr_s3, den_q);
					scph_pkg::XOP_N2: begin
						if (den_nz_q && n1ok_q && in_unit(cr_s3, den_q)) begin
							cross_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (rsp_load) begin
				rsp_valid_q           <= 1'b1;
				rsp_q.endpoint_inside <= in_poly;
				rsp_q.hit             <= in_poly || cross_q;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: bench/tb_segment_convex_polygon_hit.sv
`timescale 1ns / 1ps
// Testbench for the segment versus convex polygon hit block: directed and random items with checks.
module tb_segment_convex_polygon_hit;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TABLE_SLOTS = 16;

	// Tracks the vertex table and vertex_count, predicts the flags of each item.
	class hit_board;
		longint vx[TABLE_SLOTS];
		longint vy[TABLE_SLOTS];
		logic [scph_pkg::CFG_BITS-1:0] count;
		scph_pkg::rsp_t flags_due[$];
		int errors;

		function new();
			count = '0;
			errors = 0;
			foreach (vx[i]) begin
				vx[i] = 0;
				vy[i] = 0;
			end
		endfunction

		function void set_count(logic [scph_pkg::CFG_BITS-1:0] v);
			count = v;
		endfunction

		function int pending();
			return flags_due.size();
		endfunction

		function int in_use();
			return (count > TABLE_SLOTS) ? TABLE_SLOTS : int'(count);
		endfunction

		// zero cross product counts as inside
		function bit point_in(longint px, longint py);
			int n;
			int j;
			longint ax, ay, bx, by;
			n = in_use();
			if (n < scph_pkg::MIN_POLY_VERTICES) return 1'b0;
			for (int i = 0; i < n; i++) begin
				j = (i + 1 == n) ? 0 : i + 1;
				ax = vx[i] - px;
				ay = vy[i] - py;
				bx = vx[j] - px;
				by = vy[j] - py;
				if (ax * by - bx * ay < 0) return 1'b0;
			end
			return 1'b1;
		endfunction

		function bit within_unit(longint num, longint den);
			if (den > 0) return num >= 0 && num <= den;
			return num <= 0 && num >= den;
		endfunction

		// parameters of both lines checked against [0,1] without dividing
		function bit crosses(longint ox, longint oy, longint d1x, longint d1y,
				longint ex, longint ey, longint d2x, longint d2y);
			longint den, sx, sy;
			den = d2y * d1x - d2x * d1y;
			if (den == 0) return 1'b0;
			sx = ox - ex;
			sy = oy - ey;
			return within_unit(d2x * sy - d2y * sx, den) &&
				within_unit(d1x * sy - d1y * sx, den);
		endfunction

		function scph_pkg::rsp_t predict_flags(scph_pkg::req_t r);
			scph_pkg::rsp_t f;
			longint ox, oy, dx, dy;
			int n;
			int j;
			f = '0;
			ox = longint'($signed(r.coord_x));
			oy = longint'($signed(r.coord_y));
			dx = longint'($signed(r.dir_x));
			dy = longint'($signed(r.dir_y));
			if (r.op == scph_pkg::OP_WRITE) begin
				vx[r.vertex_index] = ox;
				vy[r.vertex_index] = oy;
			end else begin
				n = in_use();
				f.endpoint_inside = point_in(ox, oy) || point_in(ox + dx, oy + dy);
				f.hit = f.endpoint_inside;
				for (int i = 0; i < n && !f.hit; i++) begin
					j = (i + 1 == n) ? 0 : i + 1;
					f.hit = crosses(ox, oy, dx, dy, vx[i], vy[i],
						vx[j] - vx[i], vy[j] - vy[i]);
				end
			end
			return f;
		endfunction

		function void note_item(scph_pkg::req_t r);
			flags_due.push_back(predict_flags(r));
		endfunction

		function void flag_error(string field, logic want, logic got);
			errors++;
			if (errors <= 50) $error("%s mismatch: expected %0b, got %0b", field, want, got);
		endfunction

		function void check_flags(scph_pkg::rsp_t got);
			scph_pkg::rsp_t want;
			if (flags_due.size() == 0) begin
				errors++;
				if (errors <= 50)
					$error("unexpected result: hit %0b endpoint_inside %0b",
						got.hit, got.endpoint_inside);
				return;
			end
			want = flags_due.pop_front();
			if (got.hit !== want.hit) flag_error("hit", want.hit, got.hit);
			if (got.endpoint_inside !== want.endpoint_inside)
				flag_error("endpoint_inside", want.endpoint_inside, got.endpoint_inside);
		endfunction

		function void flag_leftover();
			if (flags_due.size() != 0) begin
				errors++;
				$error("%0d expected results never arrived", flags_due.size());
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_stall;
	scph_pkg::req_t                req;
	logic                          rsp_valid;
	logic                          rsp_stall;
	scph_pkg::rsp_t                rsp;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [scph_pkg::CFG_BITS-1:0] cfg_data;

	hit_board board;
	bit       quiet;
	bit       hold_req;
	int       cycle_count;

	// aim data for queries: last written vertices, polygon center and radius
	int poly_x[TABLE_SLOTS];
	int poly_y[TABLE_SLOTS];
	int pcx, pcy, pr;

	segment_convex_polygon_hit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// receiver: random stalls, quiet stretches, and one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (quiet) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < 25);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) board.check_flags(rsp);
	end

	function automatic logic signed [scph_pkg::COORD_BITS-1:0] sat16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return scph_pkg::COORD_BITS'(v);
	endfunction

	function automatic logic signed [scph_pkg::COORD_BITS-1:0] rnd16();
		return scph_pkg::COORD_BITS'($urandom);
	endfunction

	function automatic int srand(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(scph_pkg::req_t r);
		while (!quiet && $urandom_range(99) < 25) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		board.note_item(r);
		@(negedge clk);
	endtask

	task automatic send_write(int idx, logic signed [scph_pkg::COORD_BITS-1:0] x,
			logic signed [scph_pkg::COORD_BITS-1:0] y);
		scph_pkg::req_t r;
		r.op = scph_pkg::OP_WRITE;
		r.vertex_index = scph_pkg::IDX_BITS'(idx);
		r.coord_x = x;
		r.coord_y = y;
		r.dir_x = rnd16();
		r.dir_y = rnd16();
		poly_x[idx] = int'(x);
		poly_y[idx] = int'(y);
		send_item(r);
	endtask

	task automatic send_query(logic signed [scph_pkg::COORD_BITS-1:0] x,
			logic signed [scph_pkg::COORD_BITS-1:0] y,
			logic signed [scph_pkg::COORD_BITS-1:0] dx,
			logic signed [scph_pkg::COORD_BITS-1:0] dy);
		scph_pkg::req_t r;
		r.op = scph_pkg::OP_QUERY;
		r.vertex_index = scph_pkg::IDX_BITS'($urandom);
		r.coord_x = x;
		r.coord_y = y;
		r.dir_x = dx;
		r.dir_y = dy;
		send_item(r);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
	endtask

	task automatic write_count(logic [scph_pkg::CFG_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.set_count(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// vertices on a circle with jittered angles; clockwise order gives no inside hits
	task automatic make_polygon(int n, bit cw);
		real ang;
		int k;
		if ($urandom_range(99) < 25) pr = $urandom_range(2, 40);
		else pr = $urandom_range(100, 16000);
		pcx = srand(32767 - pr);
		pcy = srand(32767 - pr);
		for (int i = 0; i < n; i++) begin
			ang = 6.283185307 * (i + 0.8 * ($urandom_range(0, 999) / 1000.0)) / n;
			k = cw ? n - 1 - i : i;
			send_write(k, sat16(pcx + $rtoi(pr * $cos(ang))), sat16(pcy + $rtoi(pr * $sin(ang))));
		end
	endtask

	task automatic send_aimed(int n);
		int sel, k, m;
		sel = $urandom_range(99);
		if (n > 0 && sel < 15) begin
			// vertex to vertex: parameters land exactly on 0 or 1
			k = $urandom_range(0, n - 1);
			m = $urandom_range(0, n - 1);
			send_query(sat16(poly_x[k]), sat16(poly_y[k]), sat16(poly_x[m] - poly_x[k]),
				sat16(poly_y[m] - poly_y[k]));
		end else if (sel < 25) begin
			send_query(sat16(pcx + srand(2 * pr)), sat16(pcy + srand(2 * pr)), 0, 0);
		end else begin
			send_query(sat16(pcx + srand(2 * pr)), sat16(pcy + srand(2 * pr)),
				sat16(srand(3 * pr)), sat16(srand(3 * pr)));
		end
	endtask

	initial begin
		int cnt, n, sel;
		int phase_counts[10];
		phase_counts = '{3, 4, 31, 0, 5, 16, 2, 6, 8, 1};
		board = new();
		quiet = 1'b0;
		hold_req = 1'b0;
		pcx = 0;
		pcy = 0;
		pr = 100;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty polygon right after reset
		send_query(0, 0, 16'sh7fff, 16'sh8000);

		// 200 by 200 square around the origin in slots 0..3, extreme corners in the rest
		send_write(0, -100, -100);
		send_write(1, 100, -100);
		send_write(2, 100, 100);
		send_write(3, -100, 100);
		for (int i = 4; i < TABLE_SLOTS; i++)
			send_write(i, (i % 2) ? 16'sh7fff : 16'sh8000, (i & 2) ? 16'sh7fff : 16'sh8000);

		// single vertex: degenerate edge only
		wait_idle();
		write_count(1);
		send_query(-200, -100, 400, 0);

		// two vertices: crossing ends exactly on the edge, and a parallel pass
		wait_idle();
		write_count(2);
		send_query(0, -200, 0, 100);
		send_query(-200, -100, 400, 0);

		wait_idle();
		write_count(4);
		send_query(0, 0, 0, 0);
		send_query(-300, 0, 600, 0);
		send_query(-300, 0, 250, 0);
		send_query(-300, 300, 100, 0);
		send_query(-100, -100, 200, 200);
		send_query(-200, -100, 400, 0);
		send_query(101, 0, 100, 0);
		send_query(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_query(16'sh8000, 0, 16'sh7fff, 0);

		// count above the table size is clamped
		wait_idle();
		write_count(31);
		send_query(0, 0, 1, 1);

		for (int p = 0; p < 12; p++) begin
			wait_idle();
			quiet = (p == 2);
			cnt = (p < 10) ? phase_counts[p] : $urandom_range(0, 31);
			write_count(scph_pkg::CFG_BITS'(cnt));
			n = (cnt > TABLE_SLOTS) ? TABLE_SLOTS : cnt;
			make_polygon(n, $urandom_range(99) < 15);
			if (p == 5) hold_req = 1'b1;
			for (int q = 0; q < 40; q++) begin
				if (p == 7 && q == 20) wait_idle();
				sel = $urandom_range(99);
				if (sel < 10)
					send_write($urandom_range(0, TABLE_SLOTS - 1), rnd16(), rnd16());
				else if (sel < 30)
					send_query(rnd16(), rnd16(), rnd16(), rnd16());
				else
					send_aimed(n);
			end
		end
		quiet = 1'b0;

		wait_idle();
		repeat (100) @(negedge clk);
		board.flag_leftover();
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: segment_convex_polygon_hit.f
rtl/scph_pkg.sv
rtl/segment_convex_polygon_hit.sv
bench/tb_segment_convex_polygon_hit.sv
